// File: sv/rvm_pkg.sv
package rvm_pkg;

	// Operation codes
	localparam logic OP_MARK = 1'b0;
	localparam logic OP_READ = 1'b1;

	// Configuration register indexes
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Z = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_FACTOR_X = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_FACTOR_Y = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_FACTOR_Z = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_RES  = 3'd6;

	// Segment count limit: n saturates at N_MAX, segs = n + 1 <= 4096
	localparam logic [11:0] N_MAX = 12'd4095;

	// Quantizer issue counts and the count at which the last result lands
	localparam logic [2:0] QC_ENDS_N    = 3'd6;
	localparam logic [2:0] QC_ENDS_LAST = 3'd7;
	localparam logic [2:0] QC_AXES_N    = 3'd3;
	localparam logic [2:0] QC_AXES_LAST = 3'd4;

	// Last iteration of the bit-serial root and divide
	localparam logic [5:0] ITER_LAST = 6'd32;

	// Last of the six neighbor marks
	localparam logic [2:0] NB_LAST = 3'd5;

	typedef enum logic [1:0] {AX_X, AX_Y, AX_Z} axis_t;

	typedef enum logic [1:0] {DST_FROM, DST_TO, DST_NEW} dst_t;

	typedef enum logic [2:0] {MP_READ, MP_FROM, MP_TO, MP_NEW, MP_NB} phase_t;

	typedef enum logic [1:0] {DJ_LEN, DJ_X, DJ_Y, DJ_Z} djob_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_RD_ADDR,
		ST_RD_DATA,
		ST_QNT_ENDS,
		ST_MARK_RD,
		ST_MARK_WR,
		ST_SQUARE,
		ST_SQRT,
		ST_DIV,
		ST_DIV_END,
		ST_STEP,
		ST_QNT_SAMPLE,
		ST_DONE
	} state_t;

endpackage

// File: sv/ray_voxel_marker_top.sv
// Voxel marker for line segments in a GRID_X x GRID_Y x GRID_Z occupancy bitmap. The map
// is one synchronous memory of GRID_Y*GRID_Z rows, GRID_X bits each, and every voxel mark
// is a read-modify-write of one row through its read and write ports. After
// reset, and before a mark with clear_first set, the map is swept to zero one row a cycle
// (GRID_Y*GRID_Z rows, 4096 at the default size); no item is taken during the sweep, but
// configuration writes are. A mark whose end voxels coincide marks that one voxel only;
// otherwise setup (quantizing, squares, a 33-step bit-serial square root and four 33-step
// bit-serial divides) comes before the samples; a sample that moves diagonally also has
// its six neighbors marked. The number of samples is floor(length / min_resolution) + 1,
// at most 4096. One item is in work at a time; a finished result waits in the output
// register while the next item runs.
module ray_voxel_marker_top import rvm_pkg::*; #(
	parameter int GRID_X = 64,
	parameter int GRID_Y = 64,
	parameter int GRID_Z = 64
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic                 operation,
	input  logic signed [31:0]   from_x,
	input  logic signed [31:0]   from_y,
	input  logic signed [31:0]   from_z,
	input  logic signed [31:0]   to_x,
	input  logic signed [31:0]   to_y,
	input  logic signed [31:0]   to_z,
	input  logic                 clear_first,
	input  logic [5:0]           read_x,
	input  logic [5:0]           read_y,
	input  logic [5:0]           read_z,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic                 occupied,
	output logic [18:0]          added_count,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]          cfg_data
);

	localparam int XW = $clog2(GRID_X);
	localparam int YW = $clog2(GRID_Y);
	localparam int ZW = $clog2(GRID_Z);
	localparam int ROW_W = YW + ZW;
	localparam int ROWS = 1 << ROW_W;
	localparam int MW = ((XW > YW) ? XW : YW) > ZW ? ((XW > YW) ? XW : YW) : ZW;
	localparam int DW = MW + 2;

	typedef struct packed {
		logic [ZW-1:0] z;
		logic [YW-1:0] y;
		logic [XW-1:0] x;
	} vox_t;

	function automatic logic [32:0] mag33(input logic signed [33:0] v);
		logic [33:0] t;
		t = v[33] ? 34'(-v) : 34'(v);
		return t[32:0];
	endfunction

	// Control state
	state_t             state_q, state_d;
	logic [31:0]        org_q [3];
	logic [31:0]        fac_q [3];
	logic [31:0]        minres_q;
	logic               pend_mark_q;
	logic [ROW_W-1:0]   clr_q;
	logic               out_valid_q;
	logic               valid_s1, valid_s2;

	// Item payload and working registers
	logic signed [33:0] from_q [3];
	logic signed [33:0] to_q [3];
	logic signed [33:0] dlt_q [3];
	vox_t               fv_q, tv_q, nv_q, cur_q, rdv_q;
	logic               rd_ok_q;
	phase_t             phase_q;
	logic [2:0]         nbi_q;
	logic [2:0]         qc_q;
	logic [5:0]         it_q;
	logic [65:0]        sq_sum_q;
	logic [34:0]        sr_rem_q;
	logic [32:0]        sr_root_q;
	djob_t              job_q;
	logic [32:0]        dvd_q, dvs_q, drem_q;
	logic [12:0]        segs_q, k_q;
	logic signed [33:0] stp_q [3];
	logic signed [33:0] acc_q [3];
	logic [12:0]        inc_q [3];
	logic [12:0]        frc_q [3];
	logic [18:0]        cnt_q;
	logic               res_occ_q;
	logic               occupied_q;
	logic [18:0]        added_q;

	// Occupancy memory
	logic [GRID_X-1:0]  occ_mem_q [ROWS];
	logic [GRID_X-1:0]  rdata_q;
	logic               mem_we;
	logic [ROW_W-1:0]   mem_waddr, mem_raddr;
	logic [GRID_X-1:0]  mem_wdata;

	// Quantizer / squarer pipeline
	logic               iss_valid, iss_sq;
	axis_t              iss_axis;
	dst_t               iss_dst;
	logic signed [33:0] iss_val;
	logic [34:0]        d35;
	logic               sq_s1, sq_s2, neg_s1, neg_s2;
	axis_t              axis_s1, axis_s2;
	dst_t               dst_s1, dst_s2;
	logic [32:0]        mag_s1;
	logic [31:0]        op_s1;
	logic [48:0]        hp_s2, lp_s2;
	logic [49:0]        qsum;
	logic [33:0]        q34;
	logic [63:0]        sqv;
	logic [XW-1:0]      qx;
	logic [YW-1:0]      qy;
	logic [ZW-1:0]      qz;

	// Misc datapath
	logic               in_xfer, cfg_xfer, out_xfer;
	vox_t               tgt, nb;
	logic               hit, same_ends, diag, last_k;
	logic [MW-1:0]      adx, ady, adz;
	logic [DW-1:0]      dsum;
	logic [36:0]        srt;
	logic [34:0]        trial;
	logic               sge;
	logic [34:0]        sr_rem_nx;
	logic [32:0]        root_nx;
	logic [33:0]        drt;
	logic               dge;
	logic [32:0]        drem_nx, dvd_nx;
	logic [32:0]        minres_eff;
	logic [11:0]        n_sat;
	logic [12:0]        segs_nx;
	logic               dj_neg;
	logic signed [33:0] dj_stp;
	logic [12:0]        dj_inc;
	logic [13:0]        lane_sum [3];
	logic               lane_wrap [3];
	logic [12:0]        frc_nx [3];
	logic signed [33:0] acc_nx [3];

	assign in_stall    = (state_q != ST_IDLE);
	assign in_xfer     = in_valid && !in_stall;
	assign cfg_ready   = 1'b1;
	assign cfg_xfer    = cfg_valid && cfg_ready;
	assign out_valid   = out_valid_q;
	assign occupied    = occupied_q;
	assign added_count = added_q;
	assign out_xfer    = out_valid_q && !out_stall;

	// Select the six face and edge neighbors between cur and the new sample
	always_comb begin
		nb = nv_q;
		case (nbi_q)
			3'd0: nb = '{z: cur_q.z, y: cur_q.y, x: nv_q.x};
			3'd1: nb = '{z: cur_q.z, y: nv_q.y, x: cur_q.x};
			3'd2: nb = '{z: nv_q.z, y: cur_q.y, x: cur_q.x};
			3'd3: nb = '{z: cur_q.z, y: nv_q.y, x: nv_q.x};
			3'd4: nb = '{z: nv_q.z, y: cur_q.y, x: nv_q.x};
			3'd5: nb = '{z: nv_q.z, y: nv_q.y, x: cur_q.x};
			default: nb = nv_q;
		endcase
	end

	// Voxel addressed by the current mark or read
	always_comb begin
		case (phase_q)
			MP_READ: tgt = rdv_q;
			MP_FROM: tgt = fv_q;
			MP_TO:   tgt = tv_q;
			MP_NEW:  tgt = nv_q;
			MP_NB:   tgt = nb;
			default: tgt = fv_q;
		endcase
	end

	assign hit       = rdata_q[tgt.x];
	assign same_ends = (fv_q == tv_q);
	assign last_k    = (k_q == segs_q);

	// Diagonal move: sum of absolute index offsets above one
	always_comb begin
		adx  = MW'((nv_q.x > cur_q.x) ? nv_q.x - cur_q.x : cur_q.x - nv_q.x);
		ady  = MW'((nv_q.y > cur_q.y) ? nv_q.y - cur_q.y : cur_q.y - nv_q.y);
		adz  = MW'((nv_q.z > cur_q.z) ? nv_q.z - cur_q.z : cur_q.z - nv_q.z);
		dsum = DW'(adx) + DW'(ady) + DW'(adz);
		diag = (dsum > DW'(1));
	end

	// Bit-serial square root step, two radicand bits per cycle
	always_comb begin
		srt       = {sr_rem_q, sq_sum_q[65:64]};
		trial     = {sr_root_q, 2'b01};
		sge       = (srt >= {2'b00, trial});
		sr_rem_nx = sge ? 35'(srt - {2'b00, trial}) : srt[34:0];
		root_nx   = {sr_root_q[31:0], sge};
	end

	// Restoring divide step, one quotient bit per cycle
	always_comb begin
		drt     = {drem_q, dvd_q[32]};
		dge     = (drt >= {1'b0, dvs_q});
		drem_nx = dge ? 33'(drt - {1'b0, dvs_q}) : drt[32:0];
		dvd_nx  = {dvd_q[31:0], dge};
	end

	// Segment count and floor-division sign correction
	always_comb begin
		minres_eff = (minres_q == 32'd0) ? 33'd1 : {1'b0, minres_q};
		n_sat      = (dvd_q > 33'(N_MAX)) ? N_MAX : dvd_q[11:0];
		segs_nx    = 13'(n_sat) + 13'd1;
		case (job_q)
			DJ_X:    dj_neg = dlt_q[0][33];
			DJ_Y:    dj_neg = dlt_q[1][33];
			DJ_Z:    dj_neg = dlt_q[2][33];
			default: dj_neg = 1'b0;
		endcase
		if (dj_neg && drem_q != 33'd0) begin
			dj_stp = -$signed({1'b0, dvd_q}) - 34'sd1;
			dj_inc = segs_q - drem_q[12:0];
		end else if (dj_neg) begin
			dj_stp = -$signed({1'b0, dvd_q});
			dj_inc = 13'd0;
		end else begin
			dj_stp = $signed({1'b0, dvd_q});
			dj_inc = drem_q[12:0];
		end
	end

	// Advance each axis by its quotient, carrying the remainder
	always_comb begin
		for (int a = 0; a < 3; a++) begin
			lane_sum[a]  = {1'b0, frc_q[a]} + {1'b0, inc_q[a]};
			lane_wrap[a] = (lane_sum[a] >= {1'b0, segs_q});
			frc_nx[a]    = lane_wrap[a] ? 13'(lane_sum[a] - {1'b0, segs_q}) : lane_sum[a][12:0];
			acc_nx[a]    = acc_q[a] + stp_q[a] + (lane_wrap[a] ? 34'sd1 : 34'sd0);
		end
	end

	// Quantizer stage 1 input: offset from origin, or magnitude for squaring
	always_comb begin
		d35 = {iss_val[33], iss_val} - {{3{org_q[iss_axis][31]}}, org_q[iss_axis]};
	end

	// Quantizer stage 3: scale, clamp and square results
	always_comb begin
		qsum = 50'(hp_s2) + 50'(lp_s2 >> 16);
		q34  = qsum[49:16];
		sqv  = 64'((65'(hp_s2) << 16) + 65'(lp_s2));
		if (neg_s2)
			qx = '0;
		else if (q34 > 34'(GRID_X - 1))
			qx = XW'(GRID_X - 1);
		else
			qx = q34[XW-1:0];
		if (neg_s2)
			qy = '0;
		else if (q34 > 34'(GRID_Y - 1))
			qy = YW'(GRID_Y - 1);
		else
			qy = q34[YW-1:0];
		if (neg_s2)
			qz = '0;
		else if (q34 > 34'(GRID_Z - 1))
			qz = ZW'(GRID_Z - 1);
		else
			qz = q34[ZW-1:0];
	end

	// Next state, quantizer issue and memory write control
	always_comb begin
		state_d   = state_q;
		iss_valid = 1'b0;
		iss_sq    = 1'b0;
		iss_axis  = AX_X;
		iss_dst   = DST_NEW;
		iss_val   = acc_q[0];
		mem_we    = 1'b0;
		mem_waddr = {tgt.z, tgt.y};
		mem_wdata = rdata_q | (GRID_X'(1) << tgt.x);
		mem_raddr = {tgt.z, tgt.y};
		case (state_q)
			ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
				mem_wdata = '0;
				if (clr_q == ROW_W'(ROWS - 1))
					state_d = pend_mark_q ? ST_QNT_ENDS : ST_IDLE;
			end
			ST_IDLE: begin
				if (in_xfer) begin
					if (operation == OP_READ)
						state_d = ST_RD_ADDR;
					else if (clear_first)
						state_d = ST_CLEAR;
					else
						state_d = ST_QNT_ENDS;
				end
			end
			ST_RD_ADDR: state_d = ST_RD_DATA;
			ST_RD_DATA: state_d = ST_DONE;
			ST_QNT_ENDS: begin
				iss_valid = (qc_q < QC_ENDS_N);
				case (qc_q)
					3'd0, 3'd3: iss_axis = AX_X;
					3'd1, 3'd4: iss_axis = AX_Y;
					default:    iss_axis = AX_Z;
				endcase
				iss_dst = (qc_q < QC_AXES_N) ? DST_FROM : DST_TO;
				iss_val = (qc_q < QC_AXES_N) ? from_q[iss_axis] : to_q[iss_axis];
				if (qc_q == QC_ENDS_LAST)
					state_d = ST_MARK_RD;
			end
			ST_MARK_RD: state_d = ST_MARK_WR;
			ST_MARK_WR: begin
				mem_we = 1'b1;
				case (phase_q)
					MP_FROM: state_d = same_ends ? ST_DONE : ST_MARK_RD;
					MP_TO:   state_d = ST_SQUARE;
					MP_NEW: begin
						if (diag)
							state_d = ST_MARK_RD;
						else
							state_d = last_k ? ST_DONE : ST_STEP;
					end
					MP_NB: begin
						if (nbi_q != NB_LAST)
							state_d = ST_MARK_RD;
						else
							state_d = last_k ? ST_DONE : ST_STEP;
					end
					default: state_d = ST_DONE;
				endcase
			end
			ST_SQUARE: begin
				iss_valid = (qc_q < QC_AXES_N);
				iss_sq    = 1'b1;
				iss_axis  = axis_t'(qc_q[1:0]);
				iss_val   = dlt_q[iss_axis];
				if (qc_q == QC_AXES_LAST)
					state_d = ST_SQRT;
			end
			ST_SQRT: begin
				if (it_q == ITER_LAST)
					state_d = ST_DIV;
			end
			ST_DIV: begin
				if (it_q == ITER_LAST)
					state_d = ST_DIV_END;
			end
			ST_DIV_END: state_d = (job_q == DJ_Z) ? ST_STEP : ST_DIV;
			ST_STEP: state_d = ST_QNT_SAMPLE;
			ST_QNT_SAMPLE: begin
				iss_valid = (qc_q < QC_AXES_N);
				iss_axis  = axis_t'(qc_q[1:0]);
				iss_dst   = DST_NEW;
				iss_val   = acc_q[iss_axis];
				if (qc_q == QC_AXES_LAST)
					state_d = ST_MARK_RD;
			end
			ST_DONE: begin
				if (!out_valid_q || !out_stall)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Control registers, configuration and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			pend_mark_q <= 1'b0;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			org_q[0]    <= 32'd0;
			org_q[1]    <= 32'd0;
			org_q[2]    <= 32'd0;
			fac_q[0]    <= 32'd65536;
			fac_q[1]    <= 32'd65536;
			fac_q[2]    <= 32'd65536;
			minres_q    <= 32'd65536;
		end else begin
			state_q  <= state_d;
			valid_s1 <= iss_valid;
			valid_s2 <= valid_s1;
			if (state_q == ST_CLEAR)
				clr_q <= clr_q + ROW_W'(1);
			if (state_q == ST_IDLE && in_xfer)
				pend_mark_q <= (operation == OP_MARK) && clear_first;
			else if (state_q == ST_CLEAR && state_d != ST_CLEAR)
				pend_mark_q <= 1'b0;
			// Hold the result until its transfer; a new result may land at once
			if (state_q == ST_DONE && state_d == ST_IDLE)
				out_valid_q <= 1'b1;
			else if (out_xfer)
				out_valid_q <= 1'b0;
			if (cfg_xfer) begin
				case (cfg_index)
					REG_ORIGIN_X: org_q[0] <= cfg_data;
					REG_ORIGIN_Y: org_q[1] <= cfg_data;
					REG_ORIGIN_Z: org_q[2] <= cfg_data;
					REG_FACTOR_X: fac_q[0] <= cfg_data;
					REG_FACTOR_Y: fac_q[1] <= cfg_data;
					REG_FACTOR_Z: fac_q[2] <= cfg_data;
					REG_MIN_RES:  minres_q <= cfg_data;
					default: ;
				endcase
			end
		end
	end

	// Quantizer pipeline payload
	always_ff @(posedge clk) begin
		sq_s1   <= iss_sq;
		axis_s1 <= iss_axis;
		dst_s1  <= iss_dst;
		neg_s1  <= !iss_sq && d35[34];
		mag_s1  <= iss_sq ? mag33(iss_val) : d35[32:0];
		op_s1   <= iss_sq ? 32'(mag33(iss_val)) : fac_q[iss_axis];
		sq_s2   <= sq_s1;
		axis_s2 <= axis_s1;
		dst_s2  <= dst_s1;
		neg_s2  <= neg_s1;
		hp_s2   <= 49'(mag_s1) * 49'(op_s1[31:16]);
		lp_s2   <= 49'(mag_s1) * 49'(op_s1[15:0]);
	end

	// Item datapath
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_xfer) begin
					from_q[0] <= 34'(from_x);
					from_q[1] <= 34'(from_y);
					from_q[2] <= 34'(from_z);
					to_q[0]   <= 34'(to_x);
					to_q[1]   <= 34'(to_y);
					to_q[2]   <= 34'(to_z);
					dlt_q[0]  <= 34'(to_x) - 34'(from_x);
					dlt_q[1]  <= 34'(to_y) - 34'(from_y);
					dlt_q[2]  <= 34'(to_z) - 34'(from_z);
					rdv_q.x   <= XW'(read_x);
					rdv_q.y   <= YW'(read_y);
					rdv_q.z   <= ZW'(read_z);
					rd_ok_q   <= (32'(read_x) < 32'(GRID_X)) && (32'(read_y) < 32'(GRID_Y))
						&& (32'(read_z) < 32'(GRID_Z));
					phase_q   <= (operation == OP_READ) ? MP_READ : MP_FROM;
					nbi_q     <= 3'd0;
					qc_q      <= 3'd0;
					cnt_q     <= 19'd0;
					res_occ_q <= 1'b0;
				end
			end
			ST_RD_DATA: res_occ_q <= rd_ok_q && hit;
			ST_QNT_ENDS, ST_QNT_SAMPLE: qc_q <= qc_q + 3'd1;
			ST_MARK_WR: begin
				if (!hit)
					cnt_q <= cnt_q + 19'd1;
				case (phase_q)
					MP_FROM: phase_q <= MP_TO;
					MP_TO: begin
						qc_q     <= 3'd0;
						sq_sum_q <= '0;
					end
					MP_NEW: begin
						if (diag) begin
							phase_q <= MP_NB;
							nbi_q   <= 3'd0;
						end else begin
							cur_q <= nv_q;
						end
					end
					MP_NB: begin
						if (nbi_q == NB_LAST)
							cur_q <= nv_q;
						else
							nbi_q <= nbi_q + 3'd1;
					end
					default: ;
				endcase
			end
			ST_SQUARE: begin
				qc_q      <= qc_q + 3'd1;
				sr_rem_q  <= '0;
				sr_root_q <= '0;
				it_q      <= 6'd0;
			end
			ST_SQRT: begin
				sr_rem_q  <= sr_rem_nx;
				sr_root_q <= root_nx;
				sq_sum_q  <= sq_sum_q << 2;
				// Start the length divide with the finished root
				if (it_q == ITER_LAST) begin
					dvd_q  <= root_nx;
					dvs_q  <= minres_eff;
					drem_q <= '0;
					job_q  <= DJ_LEN;
					it_q   <= 6'd0;
				end else begin
					it_q   <= it_q + 6'd1;
				end
			end
			ST_DIV: begin
				dvd_q  <= dvd_nx;
				drem_q <= drem_nx;
				it_q   <= it_q + 6'd1;
			end
			ST_DIV_END: begin
				drem_q <= '0;
				it_q   <= 6'd0;
				case (job_q)
					DJ_LEN: begin
						segs_q <= segs_nx;
						dvd_q  <= mag33(dlt_q[0]);
						dvs_q  <= 33'(segs_nx);
						job_q  <= DJ_X;
					end
					DJ_X: begin
						stp_q[0] <= dj_stp;
						inc_q[0] <= dj_inc;
						dvd_q    <= mag33(dlt_q[1]);
						job_q    <= DJ_Y;
					end
					DJ_Y: begin
						stp_q[1] <= dj_stp;
						inc_q[1] <= dj_inc;
						dvd_q    <= mag33(dlt_q[2]);
						job_q    <= DJ_Z;
					end
					default: begin
						stp_q[2] <= dj_stp;
						inc_q[2] <= dj_inc;
						for (int a = 0; a < 3; a++) begin
							acc_q[a] <= from_q[a];
							frc_q[a] <= 13'd0;
						end
						k_q   <= 13'd0;
						cur_q <= fv_q;
					end
				endcase
			end
			ST_STEP: begin
				k_q     <= k_q + 13'd1;
				qc_q    <= 3'd0;
				phase_q <= MP_NEW;
				for (int a = 0; a < 3; a++) begin
					acc_q[a] <= acc_nx[a];
					frc_q[a] <= frc_nx[a];
				end
			end
			ST_DONE: begin
				if (state_d == ST_IDLE) begin
					occupied_q <= res_occ_q;
					added_q    <= cnt_q;
				end
			end
			default: ;
		endcase

		// Land quantizer and squarer results
		if (valid_s2) begin
			if (sq_s2) begin
				sq_sum_q <= sq_sum_q + 66'(sqv);
			end else begin
				case (dst_s2)
					DST_FROM: begin
						case (axis_s2)
							AX_X:    fv_q.x <= qx;
							AX_Y:    fv_q.y <= qy;
							default: fv_q.z <= qz;
						endcase
					end
					DST_TO: begin
						case (axis_s2)
							AX_X:    tv_q.x <= qx;
							AX_Y:    tv_q.y <= qy;
							default: tv_q.z <= qz;
						endcase
					end
					default: begin
						case (axis_s2)
							AX_X:    nv_q.x <= qx;
							AX_Y:    nv_q.y <= qy;
							default: nv_q.z <= qz;
						endcase
					end
				endcase
			end
		end
	end

	// Occupancy memory: one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (mem_we)
			occ_mem_q[mem_waddr] <= mem_wdata;
		rdata_q <= occ_mem_q[mem_raddr];
	end

endmodule

// File: sim/tb.sv
`timescale 1ns / 100ps

module tb;
	import rvm_pkg::*;

	typedef struct {
		logic               op;
		logic signed [31:0] fx, fy, fz, tx, ty, tz;
		logic               clr;
		logic [5:0]         rx, ry, rz;
	} ray_item_t;

	typedef struct {
		logic        occ;
		logic [18:0] added;
	} voxel_result_t;

	typedef struct {
		int x, y, z;
	} vox_t;

	logic                 clk, arst_n;
	logic                 in_valid, in_stall;
	logic                 operation;
	logic signed [31:0]   from_x, from_y, from_z, to_x, to_y, to_z;
	logic                 clear_first;
	logic [5:0]           read_x, read_y, read_z;
	logic                 out_valid, out_stall;
	logic                 occupied;
	logic [18:0]          added_count;
	logic                 cfg_valid, cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [31:0]          cfg_data;

	ray_voxel_marker_top uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.operation(operation),
		.from_x(from_x), .from_y(from_y), .from_z(from_z),
		.to_x(to_x), .to_y(to_y), .to_z(to_z),
		.clear_first(clear_first),
		.read_x(read_x), .read_y(read_y), .read_z(read_z),
		.out_valid(out_valid), .out_stall(out_stall),
		.occupied(occupied), .added_count(added_count),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// Shadow copy of the map and the registers
	bit [262143:0]   occ_map;
	logic [31:0]     shadow_reg [0:6];
	int              recent_vox [$];
	voxel_result_t   pending_results [$];

	int errors = 0;
	int n_marks = 0, n_reads = 0, n_clears = 0, n_results = 0, n_cfg = 0;
	int burst_left = 0;
	bit hold_req = 0;

	// Clock
	initial clk = 1'b0;
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Safety limit
	initial begin
		#400ms;
		$display("tb: FAIL");
		$finish;
	end

	// ---------------- shadow model of the block ----------------

	function automatic int quantize(longint p, logic [31:0] org, logic [31:0] fac);
		longint     d;
		logic [95:0] prod;
		logic [63:0] q;
		d = p - longint'($signed(org));
		if (d < 0) return 0;
		prod = 96'(d) * 96'(fac);
		q = prod[95:32];
		if (q > 63) return 63;
		return int'(q);
	endfunction

	function automatic vox_t point_to_voxel(longint px, longint py, longint pz);
		vox_t v;
		v.x = quantize(px, shadow_reg[REG_ORIGIN_X], shadow_reg[REG_FACTOR_X]);
		v.y = quantize(py, shadow_reg[REG_ORIGIN_Y], shadow_reg[REG_FACTOR_Y]);
		v.z = quantize(pz, shadow_reg[REG_ORIGIN_Z], shadow_reg[REG_FACTOR_Z]);
		return v;
	endfunction

	// Set one voxel, return 1 when it was newly set
	function automatic int set_voxel(vox_t v);
		int i;
		i = v.x + 64 * (v.y + 64 * v.z);
		if (occ_map[i]) return 0;
		occ_map[i] = 1'b1;
		recent_vox.push_back(i);
		if (recent_vox.size() > 64) void'(recent_vox.pop_front());
		return 1;
	endfunction

	function automatic logic [71:0] seg_length(longint dx, longint dy, longint dz);
		logic [71:0] ax, ay, az, s, r, c;
		ax = 72'(dx < 0 ? -dx : dx);
		ay = 72'(dy < 0 ? -dy : dy);
		az = 72'(dz < 0 ? -dz : dz);
		s = ax * ax + ay * ay + az * az;
		r = '0;
		for (int b = 34; b >= 0; b--) begin
			c = r | (72'd1 << b);
			if (c * c <= s) r = c;
		end
		return r;
	endfunction

	function automatic longint div_floor(longint num, longint den);
		if (num >= 0) return num / den;
		return -((-num + den - 1) / den);
	endfunction

	function automatic int abs_int(int v);
		return v < 0 ? -v : v;
	endfunction

	function automatic int trace_ray(ray_item_t it);
		longint fx, fy, fz, dx, dy, dz, segs;
		logic [71:0] len, m, n;
		vox_t fv, tv, cur, nv, nb;
		int cnt;
		fx = it.fx; fy = it.fy; fz = it.fz;
		dx = longint'(it.tx) - fx;
		dy = longint'(it.ty) - fy;
		dz = longint'(it.tz) - fz;
		fv = point_to_voxel(fx, fy, fz);
		tv = point_to_voxel(it.tx, it.ty, it.tz);
		cnt = set_voxel(fv);
		if (tv.x == fv.x && tv.y == fv.y && tv.z == fv.z) return cnt;
		cnt += set_voxel(tv);
		m = 72'(shadow_reg[REG_MIN_RES]);
		if (m == 0) m = 1;
		len = seg_length(dx, dy, dz);
		n = len / m;
		if (n > 4095) n = 4095;
		segs = longint'(n) + 1;
		cur = fv;
		for (longint k = 1; k <= segs; k++) begin
			nv = point_to_voxel(fx + div_floor(dx * k, segs), fy + div_floor(dy * k, segs),
				fz + div_floor(dz * k, segs));
			cnt += set_voxel(nv);
			// diagonal move: fill the face and edge neighbors
			if (abs_int(nv.x - cur.x) + abs_int(nv.y - cur.y) + abs_int(nv.z - cur.z) > 1) begin
				nb = cur; nb.x = nv.x; cnt += set_voxel(nb);
				nb = cur; nb.y = nv.y; cnt += set_voxel(nb);
				nb = cur; nb.z = nv.z; cnt += set_voxel(nb);
				nb = nv;  nb.z = cur.z; cnt += set_voxel(nb);
				nb = nv;  nb.y = cur.y; cnt += set_voxel(nb);
				nb = nv;  nb.x = cur.x; cnt += set_voxel(nb);
			end
			cur = nv;
		end
		return cnt;
	endfunction

	function automatic voxel_result_t predict_result(ray_item_t it);
		voxel_result_t r;
		r.occ = 1'b0;
		r.added = '0;
		if (it.op == OP_READ) begin
			r.occ = occ_map[int'(it.rx) + 64 * (int'(it.ry) + 64 * int'(it.rz))];
			n_reads++;
		end else begin
			if (it.clr) begin
				occ_map = '0;
				recent_vox.delete();
				n_clears++;
			end
			r.added = 19'(trace_ray(it));
			n_marks++;
		end
		return r;
	endfunction

	// ---------------- drivers ----------------

	task automatic send_item(ray_item_t it);
		@(negedge clk);
		in_valid = 1'b1;
		operation = it.op;
		from_x = it.fx; from_y = it.fy; from_z = it.fz;
		to_x = it.tx; to_y = it.ty; to_z = it.tz;
		clear_first = it.clr;
		read_x = it.rx; read_y = it.ry; read_z = it.rz;
		do @(posedge clk); while (in_stall);
		pending_results.push_back(predict_result(it));
		// burst ended: leave a random gap
		if (burst_left == 0) begin
			@(negedge clk);
			in_valid = 1'b0;
			repeat ($urandom_range(0, 8)) @(negedge clk);
			burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12);
		end else begin
			burst_left--;
		end
	endtask

	// Stop offering and wait for every outstanding result
	task automatic drain();
		@(negedge clk);
		in_valid = 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		do @(posedge clk); while (!cfg_ready);
		shadow_reg[idx] = data;
		n_cfg++;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic load_config(logic [31:0] ox, logic [31:0] oy, logic [31:0] oz,
		logic [31:0] kx, logic [31:0] ky, logic [31:0] kz, logic [31:0] mres);
		drain();
		write_reg(REG_ORIGIN_X, ox);
		write_reg(REG_ORIGIN_Y, oy);
		write_reg(REG_ORIGIN_Z, oz);
		write_reg(REG_FACTOR_X, kx);
		write_reg(REG_FACTOR_Y, ky);
		write_reg(REG_FACTOR_Z, kz);
		write_reg(REG_MIN_RES, mres);
	endtask

	function automatic ray_item_t mark_item(longint fx, longint fy, longint fz,
		longint tx, longint ty, longint tz, logic clr);
		ray_item_t it;
		it.op = OP_MARK;
		it.fx = 32'(fx); it.fy = 32'(fy); it.fz = 32'(fz);
		it.tx = 32'(tx); it.ty = 32'(ty); it.tz = 32'(tz);
		it.clr = clr;
		it.rx = 6'($urandom); it.ry = 6'($urandom); it.rz = 6'($urandom);
		return it;
	endfunction

	function automatic ray_item_t read_item(int x, int y, int z, logic clr);
		ray_item_t it;
		it.op = OP_READ;
		it.fx = $urandom; it.fy = $urandom; it.fz = $urandom;
		it.tx = $urandom; it.ty = $urandom; it.tz = $urandom;
		it.clr = clr;
		it.rx = 6'(x); it.ry = 6'(y); it.rz = 6'(z);
		return it;
	endfunction

	// World-space extent of the grid on one axis, capped
	function automatic longint grid_span(logic [31:0] fac);
		longint s;
		if (fac == 0) return 64 * 65536;
		s = longint'((64'd64 << 32) / fac);
		if (s < 4) s = 4;
		if (s > 64'h4000_0000) s = 64'h4000_0000;
		return s;
	endfunction

	function automatic longint rand_coord(int ax);
		longint span, org;
		span = grid_span(shadow_reg[REG_FACTOR_X + ax]);
		org = longint'($signed(shadow_reg[REG_ORIGIN_X + ax]));
		return org - span / 8 + longint'({$urandom, $urandom} % (span + span / 4 + 1));
	endfunction

	function automatic longint rand_delta(int ax);
		longint lim, m;
		m = longint'(shadow_reg[REG_MIN_RES]);
		if (m == 0) m = 1;
		lim = grid_span(shadow_reg[REG_FACTOR_X + ax]) / 3;
		if (lim > m * 40) lim = m * 40;
		if (lim < 1) lim = 1;
		return longint'({$urandom, $urandom} % (2 * lim + 1)) - lim;
	endfunction

	function automatic ray_item_t random_item();
		longint p [3];
		longint q [3];
		int sel, v;
		sel = $urandom_range(0, 99);
		if (sel < 25) begin
			// half the reads hit voxels that were just set
			if (recent_vox.size() != 0 && $urandom_range(0, 1)) begin
				v = recent_vox[$urandom_range(0, recent_vox.size() - 1)];
				return read_item(v % 64, (v / 64) % 64, v / 4096, 1'($urandom));
			end
			return read_item($urandom_range(0, 63), $urandom_range(0, 63),
				$urandom_range(0, 63), 1'($urandom));
		end
		for (int a = 0; a < 3; a++) begin
			p[a] = (sel < 35) ? longint'($signed(32'($urandom))) : rand_coord(a);
			q[a] = p[a] + rand_delta(a);
		end
		return mark_item(p[0], p[1], p[2], q[0], q[1], q[2], $urandom_range(0, 32) == 0);
	endfunction

	// ---------------- receiver ----------------

	initial begin
		int mode_left, stall_pct;
		mode_left = 0;
		stall_pct = 0;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				// long hold-off so the block backs up
				out_stall = 1'b1;
				repeat (300) @(negedge clk);
				hold_req = 1'b0;
				out_stall = 1'b0;
			end else begin
				if (mode_left == 0) begin
					mode_left = $urandom_range(16, 200);
					case ($urandom_range(0, 3))
						0: stall_pct = 0;
						1: stall_pct = 20;
						2: stall_pct = 60;
						default: stall_pct = 90;
					endcase
				end
				mode_left--;
				out_stall = ($urandom_range(0, 99) < stall_pct);
			end
		end
	end

	// Compare each result transfer with the oldest expectation
	always @(posedge clk) begin
		voxel_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			n_results++;
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result occupied=%0d added_count=%0d",
					$time, occupied, added_count);
				errors++;
			end else begin
				want = pending_results.pop_front();
				if (occupied !== want.occ) begin
					$display("%0t: occupied expected %0d actual %0d", $time, want.occ, occupied);
					errors++;
				end
				if (added_count !== want.added) begin
					$display("%0t: added_count expected %0d actual %0d",
						$time, want.added, added_count);
					errors++;
				end
			end
		end
	end

	// ---------------- tests ----------------

	task automatic test_directed_rays();
		localparam longint U = 65536;
		localparam longint H = 32768;
		load_config(32'd0, 32'd0, 32'd0, 32'h10000, 32'h10000, 32'h10000, 32'h10000);
		send_item(read_item(0, 0, 0, 1'b1));
		send_item(mark_item(U + H, U + H, U + H, U + H + 100, U + H, U + H, 1'b0));
		send_item(mark_item(H, H, H, 10 * U + H, H, H, 1'b0));
		send_item(mark_item(H, H, H, 20 * U + H, 20 * U + H, 20 * U + H, 1'b0));
		send_item(mark_item(-5 * U, -U, -1, 3 * U, 2 * U, U, 1'b0));
		send_item(mark_item(-64'sh8000_0000, -64'sh8000_0000, -64'sh8000_0000,
			-64'sh8000_0000, -64'sh8000_0000, -64'sh8000_0000, 1'b0));
		send_item(mark_item(64'sh7FFF_FFFF, 64'sh7FFF_FFFF, 64'sh7FFF_FFFF,
			64'sh7FFF_FFFF, 64'sh7FFF_FFFF, 64'sh7FFF_FFFF, 1'b0));
		// full-range segment hits the segment cap
		send_item(mark_item(-64'sh8000_0000, -64'sh8000_0000, -64'sh8000_0000,
			64'sh7FFF_FFFF, 64'sh7FFF_FFFF, 64'sh7FFF_FFFF, 1'b0));
		send_item(read_item(1, 1, 1, 1'b1));
		send_item(read_item(63, 63, 63, 1'b0));
		send_item(read_item(10, 0, 0, 1'b0));
		send_item(read_item(5, 40, 2, 1'b0));
		send_item(mark_item(2 * U, 3 * U, 4 * U, 9 * U, 3 * U, 4 * U, 1'b1));
		send_item(read_item(63, 63, 63, 1'b0));
		send_item(read_item(5, 3, 4, 1'b0));
		// zero factor on x, zero and tiny sample spacing
		load_config(32'd0, 32'd0, 32'd0, 32'd0, 32'h10000, 32'h10000, 32'd0);
		send_item(mark_item(30 * U, H, H, 2 * U, 2 * U + H, H, 1'b0));
		send_item(read_item(0, 2, 0, 1'b0));
		load_config(32'd0, 32'd0, 32'd0, 32'h10000, 32'h10000, 32'h10000, 32'd1);
		send_item(mark_item(H, H, H, 2 * U, 3 * U, H, 1'b1));
		// extreme registers
		load_config(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
			32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_item(mark_item(-64'sh8000_0000, 64'sh7FFF_FFFF, -64'sh8000_0000 + 3 * U,
			-64'sh8000_0000 + 40 * U, 64'sh7FFF_FFFF, -64'sh8000_0000, 1'b0));
		send_item(mark_item(0, 0, 0, 5, 0, -9, 1'b0));
		send_item(read_item(63, 0, 0, 1'b0));
		drain();
	endtask

	task automatic test_backpressure();
		load_config(32'd0, 32'd0, 32'd0, 32'h10000, 32'h10000, 32'h10000, 32'h10000);
		hold_req = 1'b1;
		repeat (6) send_item(random_item());
		drain();
	endtask

	task automatic random_phase(int count);
		repeat (count) send_item(random_item());
	endtask

	task automatic test_random_settings();
		load_config(32'd0, 32'd0, 32'd0, 32'h10000, 32'h10000, 32'h10000, 32'h10000);
		random_phase(250);
		load_config(32'hFFF8_0000, 32'h0004_0000, 32'hFFFF_0000,
			32'h40000, 32'h20000, 32'h40000, 32'h8000);
		random_phase(250);
		load_config(32'h0100_0000, 32'hFF00_0000, 32'h0, 32'h1000, 32'h800, 32'h0, 32'h30000);
		random_phase(250);
		load_config($urandom, $urandom, $urandom, $urandom_range(32'h4000, 32'h80000),
			$urandom_range(32'h4000, 32'h80000), $urandom_range(32'h4000, 32'h80000),
			$urandom_range(32'h4000, 32'h40000));
		random_phase(250);
		load_config(32'h7FF0_0000, 32'h8000_0000, 32'h1234_5678,
			32'hFFFF_FFFF, 32'h0001_0000, 32'h0100_0000, 32'h100);
		random_phase(250);
		load_config(32'd0, 32'd0, 32'd0, 32'h10000, 32'h10000, 32'h10000, 32'h18000);
		random_phase(250);
		drain();
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		operation = OP_MARK;
		from_x = '0; from_y = '0; from_z = '0;
		to_x = '0; to_y = '0; to_z = '0;
		clear_first = 1'b0;
		read_x = '0; read_y = '0; read_z = '0;
		cfg_valid = 1'b0;
		cfg_index = REG_ORIGIN_X;
		cfg_data = '0;
		occ_map = '0;
		shadow_reg[REG_ORIGIN_X] = 32'd0;
		shadow_reg[REG_ORIGIN_Y] = 32'd0;
		shadow_reg[REG_ORIGIN_Z] = 32'd0;
		shadow_reg[REG_FACTOR_X] = 32'h10000;
		shadow_reg[REG_FACTOR_Y] = 32'h10000;
		shadow_reg[REG_FACTOR_Z] = 32'h10000;
		shadow_reg[REG_MIN_RES] = 32'h10000;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;

		test_directed_rays();
		test_backpressure();
		test_random_settings();

		repeat (50) @(posedge clk);
		$display("tb: %0d marks (%0d with clear), %0d reads, %0d results checked",
			n_marks, n_clears, n_reads, n_results);
		$display("tb: %0d register writes over %0d settings, %0d mismatches",
			n_cfg, n_cfg / 7, errors);
		if (errors == 0 && pending_results.size() == 0) begin
			$display("tb: PASS");
		end else begin
			$display("tb: FAIL");
		end
		$finish;
	end

endmodule

// File: filelist.f
sv/rvm_pkg.sv
sv/ray_voxel_marker_top.sv
sim/tb.sv
